@@ rtl/cmf_pkg.sv @@
// cmf_pkg: types and constants shared by the coalescing message fifo modules
// no dependencies

package cmf_pkg;

  localparam int HandleW = 32;
  localparam int TopicW  = 16;
  localparam int OpW     = 2;
  localparam int StatusW = 2;

  // request opcodes; the fourth code does nothing
  typedef enum logic [OpW-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NULL  = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE   = 1'b0,
    CTRL_COMMIT = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // latch request and topic match vector
    logic commit;  // apply request to the store and load the result register
  } ctrl_cmd_t;

endpackage

@@ rtl/cmf_ctrl.sv @@
// cmf_ctrl: handshake and sequencing state machine of the coalescing message fifo
// depends on cmf_pkg

module cmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cmf_pkg::ctrl_cmd_t  cmd_o
);

  import cmf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CTRL_COMMIT;
        end
      end
      CTRL_COMMIT: begin
        // wait for room in the result register
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == CTRL_COMMIT)
    else $error("accepted request did not move to commit");
  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_commit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("commit did not present a result");
`endif

endmodule

@@ rtl/cmf_datapath.sv @@
// cmf_datapath: entry store, topic match, compaction shift and result register
// depends on cmf_pkg

module cmf_datapath #(
  parameter int DEPTH      = 16,
  parameter int TOPIC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmf_pkg::ctrl_cmd_t              cmd_i,
  input  logic [cmf_pkg::OpW-1:0]         op_i,
  input  logic [cmf_pkg::HandleW-1:0]     msg_handle_i,
  input  logic [cmf_pkg::TopicW-1:0]      topic_id_i,
  input  logic                            real_time_i,
  output logic [cmf_pkg::StatusW-1:0]     status_o,
  output logic [cmf_pkg::HandleW-1:0]     out_handle_o,
  output logic [cmf_pkg::TopicW-1:0]      out_topic_o,
  output logic                            out_real_time_o,
  output logic                            replaced_o,
  output logic [$clog2(DEPTH+1)-1:0]      occupancy_o
);

  import cmf_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SB   = (TOPIC_BITS < TopicW) ? TOPIC_BITS : TopicW;

  // entry store
  logic [HandleW-1:0] ent_handle_q [DEPTH];
  logic [SB-1:0]      ent_topic_q  [DEPTH];
  logic               ent_rt_q     [DEPTH];
  logic [HandleW-1:0] up_handle    [DEPTH];
  logic [SB-1:0]      up_topic     [DEPTH];
  logic               up_rt        [DEPTH];
  logic [CntW-1:0]    count_q, count_d;

  // latched request
  logic [OpW-1:0]     req_op_q;
  logic [HandleW-1:0] req_handle_q;
  logic [SB-1:0]      req_topic_q;
  logic               req_rt_q;
  logic [DEPTH-1:0]   match_q, match_d;

  // result register
  status_e            status_q, status_d;
  logic [HandleW-1:0] out_handle_q, out_handle_d;
  logic [SB-1:0]      out_topic_q, out_topic_d;
  logic               out_rt_q, out_rt_d;
  logic               replaced_q, replaced_d;

  logic               found;
  logic [DEPTH-1:0]   first_hit, below_hit, shift_en;
  logic               wr_en;
  logic [CntW-1:0]    tail;

  // parallel compare against live real-time entries
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = real_time_i && (CntW'(i) < count_q) && ent_rt_q[i]
                   && (ent_topic_q[i] == topic_id_i[SB-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_op_q     <= op_i;
      req_handle_q <= msg_handle_i;
      req_topic_q  <= topic_id_i[SB-1:0];
      req_rt_q     <= real_time_i;
      match_q      <= match_d;
    end
  end

  // oldest match and the entries from it upward
  assign found     = |match_q;
  assign first_hit = match_q & (~match_q + DEPTH'(1));
  assign below_hit = first_hit - DEPTH'(1);

  always_comb begin
    count_d      = count_q;
    status_d     = STATUS_OK;
    out_handle_d = '0;
    out_topic_d  = '0;
    out_rt_d     = 1'b0;
    replaced_d   = 1'b0;
    shift_en     = '0;
    wr_en        = 1'b0;
    tail         = count_q - CntW'(found);
    case (req_op_q)
      OP_PUSH: begin
        if (req_handle_q == '0) begin
          status_d = STATUS_NULL;
        end else if (!found && count_q == CntW'(DEPTH)) begin
          status_d = STATUS_FULL;
        end else begin
          replaced_d = found;
          shift_en   = found ? ~below_hit : '0;
          wr_en      = 1'b1;
          count_d    = tail + CntW'(1);
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          out_handle_d = ent_handle_q[0];
          out_topic_d  = ent_topic_q[0];
          out_rt_d     = ent_rt_q[0];
          shift_en     = '1;
          count_d      = count_q - CntW'(1);
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    if (g < DEPTH - 1) begin : g_up
      assign up_handle[g] = ent_handle_q[g+1];
      assign up_topic[g]  = ent_topic_q[g+1];
      assign up_rt[g]     = ent_rt_q[g+1];
    end else begin : g_top
      assign up_handle[g] = ent_handle_q[g];
      assign up_topic[g]  = ent_topic_q[g];
      assign up_rt[g]     = ent_rt_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (wr_en && tail == CntW'(g)) begin
          ent_handle_q[g] <= req_handle_q;
          ent_topic_q[g]  <= req_topic_q;
          ent_rt_q[g]     <= req_rt_q;
        end else if (shift_en[g]) begin
          ent_handle_q[g] <= up_handle[g];
          ent_topic_q[g]  <= up_topic[g];
          ent_rt_q[g]     <= up_rt[g];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= status_d;
      out_handle_q <= out_handle_d;
      out_topic_q  <= out_topic_d;
      out_rt_q     <= out_rt_d;
      replaced_q   <= replaced_d;
    end
  end

  assign status_o        = status_q;
  assign out_handle_o    = out_handle_q;
  assign out_topic_o     = TopicW'(out_topic_q);
  assign out_real_time_o = out_rt_q;
  assign replaced_o      = replaced_q;
  assign occupancy_o     = count_q;

`ifndef NO_ASSERTIONS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy above depth");
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(first_hit))
    else $error("more than one replacement position");
  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && req_op_q == OP_POP && count_q != '0
    |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not reduce occupancy by one");
`endif

endmodule

@@ rtl/coalescing_message_fifo.sv @@
// coalescing_message_fifo: an accepted request is latched with its parallel topic match, then
// committed as one compaction shift that loads the registered result once an earlier result
// has been taken; a new request is accepted only after the previous one has committed.
// reset (asynchronous, active low) empties the queue and clears the handshake state;
// entry contents are not cleared and are never read before being written.
// depends on cmf_pkg, cmf_ctrl, cmf_datapath

module coalescing_message_fifo #(
  parameter int DEPTH      = 16,
  parameter int TOPIC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cmf_pkg::OpW-1:0]         op_i,
  input  logic [cmf_pkg::HandleW-1:0]     msg_handle_i,
  input  logic [cmf_pkg::TopicW-1:0]      topic_id_i,
  input  logic                            real_time_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cmf_pkg::StatusW-1:0]     status_o,
  output logic [cmf_pkg::HandleW-1:0]     out_handle_o,
  output logic [cmf_pkg::TopicW-1:0]      out_topic_o,
  output logic                            out_real_time_o,
  output logic                            replaced_o,
  output logic [$clog2(DEPTH+1)-1:0]      occupancy_o
);

  import cmf_pkg::*;

  // commands from the sequencer to the store
  ctrl_cmd_t cmd;

  // sequencer: idle takes a request, commit waits for the result register
  // to be free and then updates the store and the result register
  cmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // store: entries kept oldest first in a shift line; a real-time push
  // removes the oldest live real-time entry of the same topic by shifting
  // everything above it down one place, then the new entry lands at the tail
  cmf_datapath #(
    .DEPTH      (DEPTH),
    .TOPIC_BITS (TOPIC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (op_i),
    .msg_handle_i    (msg_handle_i),
    .topic_id_i      (topic_id_i),
    .real_time_i     (real_time_i),
    .status_o        (status_o),
    .out_handle_o    (out_handle_o),
    .out_topic_o     (out_topic_o),
    .out_real_time_o (out_real_time_o),
    .replaced_o      (replaced_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

@@ dv/tb_coalescing_message_fifo.sv @@
// tb_coalescing_message_fifo: self-checking bench for the coalescing message fifo
// walks a directed table, then random requests under several idling phases
// depends on cmf_pkg and coalescing_message_fifo
`timescale 1ns / 1ps

module tb_coalescing_message_fifo;
  import cmf_pkg::*;

  localparam int DEPTH = 16;
  localparam int TOPIC_BITS = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int STIM_ROWS = 32;
  localparam int RING_DEPTH = 8;
  // the fourth opcode has no name in the package; the block treats it as a no-op
  localparam logic [OpW-1:0] OP_NONE = 2'd3;

  // one result as the block reports it
  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] handle;
    logic [TopicW-1:0]  topic;
    logic               rt;
    logic               replaced;
    logic [OCC_W-1:0]   occupancy;
  } fifo_result_t;

  // one line of the directed table; typed rows carry their own expected status and occupancy
  typedef struct {
    logic [OpW-1:0]     op;
    logic [HandleW-1:0] handle;
    logic [TopicW-1:0]  topic;
    logic               rt;
    int                 reps;
    bit                 typed;
    status_e            st;
    logic [OCC_W-1:0]   occ;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     op_i = OP_PUSH;
  logic [HandleW-1:0] msg_handle_i = '0;
  logic [TopicW-1:0]  topic_id_i = '0;
  logic               real_time_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [HandleW-1:0] out_handle_o;
  logic [TopicW-1:0]  out_topic_o;
  logic               out_real_time_o;
  logic               replaced_o;
  logic [OCC_W-1:0]   occupancy_o;

  coalescing_message_fifo #(
    .DEPTH      (DEPTH),
    .TOPIC_BITS (TOPIC_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .msg_handle_i    (msg_handle_i),
    .topic_id_i      (topic_id_i),
    .real_time_i     (real_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_handle_o    (out_handle_o),
    .out_topic_o     (out_topic_o),
    .out_real_time_o (out_real_time_o),
    .replaced_o      (replaced_o),
    .occupancy_o     (occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the queue contents, oldest entry at index 0
  logic [HandleW-1:0] held_handle [DEPTH];
  logic [TopicW-1:0]  held_topic  [DEPTH];
  logic               held_rt     [DEPTH];
  int                 held_count = 0;

  // expected results in acceptance order, kept in a small ring
  fifo_result_t want_ring [RING_DEPTH];
  int           ring_wr = 0;
  int           ring_rd = 0;

  stim_row_t    stim_table [STIM_ROWS];
  int           stim_rows = 0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int cycle_count = 0;

  // drop entry at pos and close up the entries behind it
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_handle[i] = held_handle[i + 1];
      held_topic[i]  = held_topic[i + 1];
      held_rt[i]     = held_rt[i + 1];
    end
    held_count--;
  endfunction

  // apply one accepted request to the shadow queue and return the result it should give
  function automatic fifo_result_t apply_request(input logic [OpW-1:0] op,
                                                 input logic [HandleW-1:0] handle,
                                                 input logic [TopicW-1:0] topic,
                                                 input logic rt);
    fifo_result_t res;
    int           pos;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_PUSH: begin
        if (handle == '0) begin
          res.status = STATUS_NULL;
        end else begin
          // a real-time push coalesces with the oldest real-time entry of its topic
          pos = -1;
          if (rt) begin
            for (int i = 0; i < held_count; i++) begin
              if (pos < 0 && held_rt[i] && held_topic[i] == topic) pos = i;
            end
          end
          if (pos >= 0) begin
            close_gap(pos);
            res.replaced = 1'b1;
          end
          if (held_count >= DEPTH) begin
            res.status = STATUS_FULL;
          end else begin
            held_handle[held_count] = handle;
            held_topic[held_count]  = topic;
            held_rt[held_count]     = rt;
            held_count++;
          end
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.handle = held_handle[0];
          res.topic  = held_topic[0];
          res.rt     = held_rt[0];
          close_gap(0);
        end
      end
      OP_CLEAR: held_count = 0;
      default: ;
    endcase
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  task automatic add_row(input logic [OpW-1:0] op, input logic [HandleW-1:0] handle,
                         input logic [TopicW-1:0] topic, input logic rt, input int reps,
                         input bit typed, input status_e st, input int occ);
    stim_row_t row;
    row.op = op;
    row.handle = handle;
    row.topic = topic;
    row.rt = rt;
    row.reps = reps;
    row.typed = typed;
    row.st = st;
    row.occ = OCC_W'(occ);
    stim_table[stim_rows] = row;
    stim_rows++;
  endtask

  // present one request, hold it until accepted, then queue its expected result
  task automatic send_request(input logic [OpW-1:0] op, input logic [HandleW-1:0] handle,
                              input logic [TopicW-1:0] topic, input logic rt,
                              input bit typed, input fifo_result_t typed_res);
    int           gap;
    fifo_result_t predicted;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    msg_handle_i <= handle;
    topic_id_i   <= topic;
    real_time_i  <= rt;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_request(op, handle, topic, rt);
    want_ring[ring_wr % RING_DEPTH] = typed ? typed_res : predicted;
    ring_wr++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ring_wr != ring_rd) @(posedge clk_i);
  endtask

  // random request biased towards pushes on a few shared topics so that
  // coalescing and the full queue both come up often
  task automatic random_request(output logic [OpW-1:0] op, output logic [HandleW-1:0] handle,
                                output logic [TopicW-1:0] topic, output logic rt);
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) op = OP_PUSH;
    else if (pick < 89) op = OP_POP;
    else if (pick < 94) op = OP_CLEAR;
    else op = OP_NONE;
    handle = ($urandom_range(99) < 5) ? '0 : HandleW'($urandom);
    case ($urandom_range(7))
      0: topic = 16'h0000;
      1: topic = 16'hffff;
      2: topic = 16'h00a5;
      3: topic = 16'h8001;
      4: topic = 16'h5a3c;
      default: topic = TopicW'($urandom);
    endcase
    rt = ($urandom_range(99) < 60);
  endtask

  task automatic report_mismatch(input string what, input logic [HandleW-1:0] got,
                                 input logic [HandleW-1:0] want);
    mismatch_count++;
    $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // receiver side: random stalls at the current phase rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    fifo_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ring_wr == ring_rd) begin
        report_mismatch("result with nothing outstanding, status", HandleW'(status_o), '0);
      end else begin
        want = want_ring[ring_rd % RING_DEPTH];
        ring_rd++;
        if (status_o != want.status)
          report_mismatch("status", HandleW'(status_o), HandleW'(want.status));
        if (out_handle_o != want.handle) report_mismatch("handle", out_handle_o, want.handle);
        if (out_topic_o != want.topic)
          report_mismatch("topic", HandleW'(out_topic_o), HandleW'(want.topic));
        if (out_real_time_o != want.rt)
          report_mismatch("real_time", HandleW'(out_real_time_o), HandleW'(want.rt));
        if (replaced_o != want.replaced)
          report_mismatch("replaced", HandleW'(replaced_o), HandleW'(want.replaced));
        if (occupancy_o != want.occupancy)
          report_mismatch("occupancy", HandleW'(occupancy_o), HandleW'(want.occupancy));
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coalescing_message_fifo: mismatch");
      $finish;
    end
  end

  initial begin
    fifo_result_t       typed_res;
    logic [OpW-1:0]     op;
    logic [HandleW-1:0] handle;
    logic [TopicW-1:0]  topic;
    logic               rt;
    int                 idle_by_phase  [4];
    int                 stall_by_phase [4];

    idle_by_phase  = '{0, 46, 0, 28};
    stall_by_phase = '{0, 0, 46, 28};

    // directed table: empty queue codes, coalescing, then fill to full and beyond
    add_row(OP_POP,   32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_EMPTY, 0);
    add_row(OP_PUSH,  32'h0,        16'hffff, 1'b1, 1,  1'b1, STATUS_NULL,  0);
    add_row(OP_CLEAR, 32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_OK,    0);
    add_row(OP_NONE,  32'hffffffff, 16'hffff, 1'b1, 1,  1'b1, STATUS_OK,    0);
    add_row(OP_PUSH,  32'hffffffff, 16'hffff, 1'b1, 1,  1'b0, STATUS_OK,    0);
    add_row(OP_PUSH,  32'h00000001, 16'h0000, 1'b0, 1,  1'b0, STATUS_OK,    0);
    // same topic, real-time: the first entry goes
    add_row(OP_PUSH,  32'h80000000, 16'hffff, 1'b1, 1,  1'b0, STATUS_OK,    0);
    // same topic but not real-time: no coalescing
    add_row(OP_PUSH,  32'h7fffffff, 16'hffff, 1'b0, 1,  1'b0, STATUS_OK,    0);
    // real-time, but the only topic-0 entry is not real-time
    add_row(OP_PUSH,  32'h00000002, 16'h0000, 1'b1, 1,  1'b0, STATUS_OK,    0);
    add_row(OP_POP,   32'h0,        16'h0,    1'b0, 2,  1'b0, STATUS_OK,    0);
    add_row(OP_CLEAR, 32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_OK,    0);
    add_row(OP_PUSH,  32'h00000100, 16'h0005, 1'b0, 14, 1'b0, STATUS_OK,    0);
    add_row(OP_PUSH,  32'ha5a5a5a5, 16'h0007, 1'b1, 1,  1'b0, STATUS_OK,    0);
    add_row(OP_PUSH,  32'h5a5a5a5a, 16'h0009, 1'b1, 1,  1'b0, STATUS_OK,    0);
    // queue full and nothing to coalesce with: dropped
    add_row(OP_PUSH,  32'h00000033, 16'h0007, 1'b0, 1,  1'b1, STATUS_FULL,  16);
    // queue full but the coalesced entry makes room
    add_row(OP_PUSH,  32'h00000044, 16'h0009, 1'b1, 1,  1'b0, STATUS_OK,    0);
    add_row(OP_PUSH,  32'h0,        16'h0007, 1'b1, 1,  1'b1, STATUS_NULL,  16);
    add_row(OP_NONE,  32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_OK,    16);
    add_row(OP_POP,   32'h0,        16'h0,    1'b0, 1,  1'b0, STATUS_OK,    0);
    add_row(OP_CLEAR, 32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_OK,    0);
    add_row(OP_POP,   32'h0,        16'h0,    1'b0, 1,  1'b1, STATUS_EMPTY, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < stim_rows; r++) begin
      for (int k = 0; k < stim_table[r].reps; k++) begin
        typed_res = '0;
        typed_res.status = stim_table[r].st;
        typed_res.occupancy = stim_table[r].occ;
        send_request(stim_table[r].op, stim_table[r].handle + HandleW'(k),
                     stim_table[r].topic, stim_table[r].rt, stim_table[r].typed, typed_res);
      end
    end
    wait_for_results();

    // random part, one phase per idling pattern, draining between phases
    typed_res = '0;
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = idle_by_phase[ph];
      out_stall_pct = stall_by_phase[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_request(op, handle, topic, rt);
        send_request(op, handle, topic, rt, 1'b0, typed_res);
      end
      wait_for_results();
    end

    out_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && ring_wr == ring_rd) begin
      $display("coalescing_message_fifo: match");
    end else begin
      $display("coalescing_message_fifo: mismatch");
    end
    $finish;
  end

endmodule
